// ===== hw/rtl/annb_pkg.sv =====
// types and codes shared by the annex b nal unit splitter
package annb_pkg;

   localparam int unsigned MaxResults = 4;
   localparam int unsigned CountWidth = $clog2(MaxResults + 1);

   typedef enum logic [2:0] {
      ST_SEARCH0 = 3'd0,
      ST_SEARCH1 = 3'd1,
      ST_SEARCH2 = 3'd2,
      ST_UNIT0   = 3'd3,
      ST_UNIT1   = 3'd4,
      ST_UNIT2   = 3'd5
   } scan_state_type;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       stream_end;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       has_byte;
      logic       unit_end;
      logic       run_last;
   } rsp_payload_type;

   // one buffered result before run_last is attached
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       has_byte;
      logic       unit_end;
   } res_entry_type;

   localparam res_entry_type EntryZero = '{payload_byte: 8'h00, has_byte: 1'b1,
                                          unit_end: 1'b0};
   localparam res_entry_type EntryEnd  = '{payload_byte: 8'h00, has_byte: 1'b0,
                                          unit_end: 1'b1};

endpackage

// ===== hw/rtl/annb_if.sv =====
// valid/ready channels for the byte stream input and the result output
interface annb_req_if
   import annb_pkg::*;
   ();
   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface annb_rsp_if
   import annb_pkg::*;
   ();
   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/annexb_nal_unit_splitter_unit.sv =====
// Annex B start code parser: splits a byte stream into NAL unit bytes and unit-end markers.
// One stream byte is taken per item on req_ch and produces zero to four results on rsp_ch,
// one result per cycle while rsp_ch.ready is high. The scan state is updated in the cycle
// the byte is taken, and its results go into a four-entry result buffer that drains at one
// entry per cycle while rsp_ch.ready is high. A new byte is taken while the buffer is
// empty or while its last entry leaves, so the drain of the result buffer sets the byte
// rate. Bytes ahead of the first 00 00 01 are discarded, extra zeros of a start code are
// dropped, and zeros held at a start code or stream end vanish.
module annexb_nal_unit_splitter_unit
   import annb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   annb_req_if.sink    req_ch,
   annb_rsp_if.source  rsp_ch
);

   scan_state_type        state_ff;
   scan_state_type        state_in;
   logic [CountWidth-1:0] rem_ff;
   res_entry_type         res_ff [MaxResults];

   res_entry_type         res_c [MaxResults];
   logic [CountWidth-1:0] cnt_c;
   logic [7:0]            b;
   logic                  push;
   logic                  pop;

   assign b    = req_ch.data.stream_byte;
   assign push = req_ch.valid && req_ch.ready;
   assign pop  = rsp_ch.valid && rsp_ch.ready;

   // take a byte when the buffer is empty or its last entry leaves now
   assign req_ch.ready = (rem_ff == '0) || ((rem_ff == CountWidth'(1)) && rsp_ch.ready);

   assign rsp_ch.valid             = (rem_ff != '0);
   assign rsp_ch.data.payload_byte = res_ff[0].payload_byte;
   assign rsp_ch.data.has_byte     = res_ff[0].has_byte;
   assign rsp_ch.data.unit_end     = res_ff[0].unit_end;
   assign rsp_ch.data.run_last     = (rem_ff == CountWidth'(1));

   // next scan state and the results of one byte
   always_comb begin
      state_in = state_ff;
      cnt_c    = '0;
      for (int i = 0; i < MaxResults; i++) begin
         res_c[i] = EntryEnd;
      end
      case (state_ff)
         ST_SEARCH1: begin
            state_in = (b == 8'h00) ? ST_SEARCH2 : ST_SEARCH0;
         end
         ST_SEARCH2: begin
            if (b == 8'h01) begin
               state_in = ST_UNIT0;
            end else if (b != 8'h00) begin
               state_in = ST_SEARCH0;
            end
         end
         ST_UNIT0: begin
            if (b != 8'h00) begin
               res_c[0] = '{payload_byte: b, has_byte: 1'b1, unit_end: 1'b0};
               cnt_c    = CountWidth'(1);
            end else begin
               state_in = ST_UNIT1;
            end
         end
         ST_UNIT1: begin
            if (b != 8'h00) begin
               res_c[0] = EntryZero;
               res_c[1] = '{payload_byte: b, has_byte: 1'b1, unit_end: 1'b0};
               cnt_c    = CountWidth'(2);
               state_in = ST_UNIT0;
            end else begin
               state_in = ST_UNIT2;
            end
         end
         ST_UNIT2: begin
            // start code inside a unit closes it and opens the next one
            if (b == 8'h01) begin
               res_c[0] = EntryEnd;
               cnt_c    = CountWidth'(1);
               state_in = ST_UNIT0;
            end else if (b != 8'h00) begin
               res_c[0] = EntryZero;
               res_c[1] = EntryZero;
               res_c[2] = '{payload_byte: b, has_byte: 1'b1, unit_end: 1'b0};
               cnt_c    = CountWidth'(3);
               state_in = ST_UNIT0;
            end
         end
         default: begin
            state_in = (b == 8'h00) ? ST_SEARCH1 : ST_SEARCH0;
         end
      endcase
      if (req_ch.data.stream_end) begin
         if ((state_in == ST_UNIT0) || (state_in == ST_UNIT1) || (state_in == ST_UNIT2)) begin
            res_c[cnt_c[1:0]] = EntryEnd;
            cnt_c             = cnt_c + CountWidth'(1);
         end
         state_in = ST_SEARCH0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SEARCH0;
         rem_ff   <= '0;
      end else if (push) begin
         state_ff <= state_in;
         rem_ff   <= cnt_c;
      end else if (pop) begin
         rem_ff <= rem_ff - CountWidth'(1);
      end
   end

   // result buffer: loaded whole on a new byte, shifted down as entries leave
   always_ff @(posedge clock) begin
      if (push) begin
         for (int i = 0; i < MaxResults; i++) begin
            res_ff[i] <= res_c[i];
         end
      end else if (pop) begin
         for (int i = 0; i < MaxResults - 1; i++) begin
            res_ff[i] <= res_ff[i + 1];
         end
      end
   end

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      rem_ff <= CountWidth'(MaxResults))
      else $error("result count above buffer depth");

   a_drain_step: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (rem_ff == $past(rem_ff) - CountWidth'(1)))
      else $error("result buffer did not drain by one");

   a_result_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.data.has_byte != rsp_ch.data.unit_end))
      else $error("result is neither a byte nor a unit end");

   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      (push && req_ch.data.stream_end) |=> (state_ff == ST_SEARCH0))
      else $error("scan state not cleared after stream end");

endmodule
